// ===== rtl/keyframe_animation_stepper_macros.svh =====
// Assertion macros for the keyframe animation stepper.
`ifndef KEYFRAME_ANIMATION_STEPPER_MACROS_SVH
`define KEYFRAME_ANIMATION_STEPPER_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/kas_pkg.sv =====
package kas_pkg;

  typedef enum logic [3:0] {
    S_IDLE, S_BIND, S_DIV1, S_MAIN, S_DIV2, S_WRAP, S_DIV3,
    S_APPLY, S_FIX, S_BLEND, S_DIV4, S_OUT
  } state_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ACOUNT   = 3'd6;

  localparam int DVD_W = 50;
  localparam int DSR_W = 33;
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] DIV_LONG  = 6'd50;
  localparam logic [CNT_W-1:0] DIV_SHORT = 6'd32;

  typedef struct packed {
    logic             start;
    logic             long_op;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/kas_if.sv =====
interface kas_item_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] now_time;
  logic signed [31:0] end_time;
  logic [9:0]         anim_number;
  modport source(output valid, now_time, end_time, anim_number, input ready);
  modport sink(input valid, now_time, end_time, anim_number, output ready);
endinterface

interface kas_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] prev_frame;
  logic [15:0] cur_frame;
  logic [15:0] prev_model;
  logic [15:0] cur_model;
  logic [16:0] back_blend;
  logic        anim_valid;
  modport source(output valid, prev_frame, cur_frame, prev_model, cur_model,
                 back_blend, anim_valid, input ready);
  modport sink(input valid, prev_frame, cur_frame, prev_model, cur_model,
               back_blend, anim_valid, output ready);
endinterface

interface kas_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/keyframe_animation_stepper.sv =====
// Keyframe animation stepper.
// One item per render tick on the item channel: now_time, end_time and
// anim_number. One result per item on the result channel: both frames, their
// model ids, a Q1.16 backward blend factor and a valid flag.
// Descriptor registers are written on the cfg channel (always ready); index
// out of range is dropped. Write only while the block is idle.
// The block handles one item at a time; item.ready is high only when idle.
// Divisions share one shift-subtract divider: frame offsets and the loop
// remainder take 32 steps each, and the blend uses it as well.
// A finished result sits in an output register; the next item is taken while
// it waits. If the receiver stalls and a second result is done, the block
// holds it and stays busy until the register frees.
// Reset (synchronous, rst high) loads the descriptor defaults, clears the
// binding and all frame and time state, and empties the output register.
`include "keyframe_animation_stepper_macros.svh"
module keyframe_animation_stepper #(
  parameter int TOGGLE_BIT = 512,
  parameter int MAX_ANIMS  = 1024
) (
  input  logic         clk,
  input  logic         rst,
  kas_cfg_if.sink      cfg,
  kas_item_if.sink     item,
  kas_result_if.source result
);

  localparam logic [9:0]  TOGGLE_MASK = ~10'(TOGGLE_BIT);
  localparam logic [10:0] MAX_A       = 11'(MAX_ANIMS);
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  // descriptor
  logic [14:0] first_frame;
  logic [15:0] frame_count, frame_period, loop_frames, model_id;
  logic [30:0] anim_duration;
  logic [10:0] anim_count;

  // latched tick
  logic signed [31:0] now_t, end_t;
  logic [9:0]         number;

  // animation state
  logic [9:0]         bound_number;
  logic               bound_flag;
  logic [15:0]        frame_now, frame_before, model_now, model_before;
  logic signed [31:0] next_time, prev_time, start_time;

  logic [31:0] offset;
  logic [16:0] back_r;
  logic        valid_r;
  logic        out_valid;

  kas_pkg::state_t   state, state_next;
  kas_pkg::div_req_t div_req;
  kas_pkg::div_rsp_t div_rsp;

  kas_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // configuration
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      first_frame   <= 15'd0;
      frame_count   <= 16'd1;
      frame_period  <= 16'd50;
      anim_duration <= 31'd50;
      loop_frames   <= 16'd0;
      model_id      <= 16'd0;
      anim_count    <= 11'd1;
    end else if (cfg.valid) begin
      case (cfg.index)
        kas_pkg::CFG_FIRST:    first_frame   <= cfg.data[14:0];
        kas_pkg::CFG_COUNT:    frame_count   <= cfg.data[15:0];
        kas_pkg::CFG_PERIOD:   frame_period  <= cfg.data[15:0];
        kas_pkg::CFG_DURATION: anim_duration <= cfg.data[30:0];
        kas_pkg::CFG_LOOP:     loop_frames   <= cfg.data[15:0];
        kas_pkg::CFG_MODEL:    model_id      <= cfg.data[15:0];
        kas_pkg::CFG_ACOUNT:   anim_count    <= cfg.data[10:0];
        default: ;
      endcase
    end
  end

  // --- derived values on the latched tick ---
  logic [9:0]  anim_index;
  logic        desc_ok, rebind, past_end;
  logic signed [32:0] left_ms;          // end - now
  logic [30:0] rem_ms, dvd1;
  logic signed [33:0] start_sum;
  logic signed [31:0] now_m1, start_new, next_adv;
  logic signed [32:0] next_sum, span2, lim200;
  logic [15:0] nm1;
  logic signed [32:0] bd, be, bd_abs, be_abs;
  logic [18:0] q_round;

  assign anim_index = number & TOGGLE_MASK;
  assign desc_ok = anim_count != 11'd0 && anim_count <= MAX_A &&
                   {1'b0, anim_index} < anim_count && frame_count != 16'd0 &&
                   frame_period != 16'd0 && loop_frames <= frame_count;
  assign rebind   = !bound_flag || bound_number != number;
  assign past_end = end_t < now_t;
  assign nm1      = frame_count - 16'd1;

  // late join: remaining time clamped to [0, duration]
  assign left_ms = 33'(end_t) - 33'(now_t);
  always_comb begin
    if (left_ms < 0) rem_ms = 31'd0;
    else if (left_ms > $signed({2'b00, anim_duration})) rem_ms = anim_duration;
    else rem_ms = left_ms[30:0];
  end
  assign dvd1      = anim_duration - rem_ms;
  assign now_m1    = (now_t == INT_MIN) ? INT_MIN : now_t - 32'sd1;
  assign start_sum = 34'(now_t) + $signed({3'b000, rem_ms}) -
                     $signed({3'b000, anim_duration});
  assign start_new = (start_sum < 34'(INT_MIN)) ? INT_MIN : start_sum[31:0];

  // frame advance
  assign next_sum = 33'(next_time) + $signed({17'd0, frame_period});
  assign next_adv = (next_sum > 33'(INT_MAX)) ? INT_MAX : next_sum[31:0];
  assign span2    = 33'(next_adv) - 33'(start_time);
  assign lim200   = 33'(now_t) + 33'sd200;

  // blend
  assign bd     = 33'(next_time) - 33'(prev_time);
  assign be     = 33'(now_t) - 33'(prev_time);
  assign bd_abs = bd[32] ? -bd : bd;
  assign be_abs = bd[32] ? -be : be;
  assign q_round = (19'(div_rsp.quotient[17:0]) + 19'd1) >> 1;

  assign item.ready = state == kas_pkg::S_IDLE;

  // --- sequencer ---
  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.long_op  = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = {17'd0, frame_period};
    case (state)
      kas_pkg::S_IDLE:
        if (item.valid) state_next = kas_pkg::S_BIND;
      kas_pkg::S_BIND: begin
        if (!desc_ok) state_next = kas_pkg::S_OUT;
        else if (rebind) begin
          state_next       = kas_pkg::S_DIV1;
          div_req.start    = 1'b1;
          div_req.dividend = {1'b0, dvd1, 18'd0};
        end else state_next = kas_pkg::S_MAIN;
      end
      kas_pkg::S_DIV1:
        if (div_rsp.done) state_next = kas_pkg::S_MAIN;
      kas_pkg::S_MAIN: begin
        if (past_end) state_next = kas_pkg::S_OUT;
        else if (now_t >= next_time) begin
          if (now_t < start_time || span2 < 0) state_next = kas_pkg::S_WRAP;
          else begin
            state_next       = kas_pkg::S_DIV2;
            div_req.start    = 1'b1;
            div_req.dividend = {span2[31:0], 18'd0};
          end
        end else state_next = kas_pkg::S_FIX;
      end
      kas_pkg::S_DIV2:
        if (div_rsp.done) state_next = kas_pkg::S_WRAP;
      kas_pkg::S_WRAP: begin
        if (offset >= {16'd0, frame_count} && loop_frames != 16'd0) begin
          state_next       = kas_pkg::S_DIV3;
          div_req.start    = 1'b1;
          div_req.dividend = {offset - {16'd0, frame_count}, 18'd0};
          div_req.divisor  = {17'd0, loop_frames};
        end else state_next = kas_pkg::S_APPLY;
      end
      kas_pkg::S_DIV3:
        if (div_rsp.done) state_next = kas_pkg::S_APPLY;
      kas_pkg::S_APPLY: state_next = kas_pkg::S_FIX;
      kas_pkg::S_FIX:   state_next = kas_pkg::S_BLEND;
      kas_pkg::S_BLEND: begin
        if (bd == 0 || be_abs < 0 || be_abs > bd_abs) state_next = kas_pkg::S_OUT;
        else begin
          state_next       = kas_pkg::S_DIV4;
          div_req.start    = 1'b1;
          div_req.long_op  = 1'b1;
          div_req.dividend = {1'b0, be_abs[31:0], 17'd0};
          div_req.divisor  = bd_abs;
        end
      end
      kas_pkg::S_DIV4:
        if (div_rsp.done) state_next = kas_pkg::S_OUT;
      kas_pkg::S_OUT:
        if (!out_valid || result.ready) state_next = kas_pkg::S_IDLE;
      default: state_next = kas_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= kas_pkg::S_IDLE;
    else     state <= state_next;
  end

  // --- datapath ---
  always_ff @(posedge clk) begin
    if (rst) begin
      bound_number <= '0;
      bound_flag   <= 1'b0;
      frame_now    <= '0;
      frame_before <= '0;
      model_now    <= '0;
      model_before <= '0;
      next_time    <= '0;
      prev_time    <= '0;
      start_time   <= '0;
    end else begin
      case (state)
        kas_pkg::S_IDLE:
          if (item.valid) begin
            now_t  <= item.now_time;
            end_t  <= item.end_time;
            number <= item.anim_number;
          end
        kas_pkg::S_BIND: begin
          valid_r <= desc_ok;
          back_r  <= 17'd0;
          if (!desc_ok) begin
            bound_flag   <= 1'b0;
            frame_now    <= '0;
            frame_before <= '0;
            model_now    <= '0;
            model_before <= '0;
          end
        end
        kas_pkg::S_DIV1:
          if (div_rsp.done) begin
            bound_flag   <= 1'b1;
            bound_number <= number;
            // offset clamped to the last frame
            if (div_rsp.quotient[31:0] >= {16'd0, frame_count})
              frame_now <= 16'({1'b0, first_frame}) + nm1;
            else
              frame_now <= 16'({1'b0, first_frame}) + div_rsp.quotient[15:0];
            next_time  <= now_m1;
            start_time <= start_new;
            model_now  <= model_id;
          end
        kas_pkg::S_MAIN: begin
          if (past_end) begin
            frame_now    <= 16'({1'b0, first_frame}) + nm1;
            frame_before <= 16'({1'b0, first_frame}) + nm1;
            model_now    <= model_id;
            model_before <= model_id;
          end else if (now_t >= next_time) begin
            frame_before <= frame_now;
            model_before <= model_now;
            prev_time    <= next_time;
            offset       <= '0;
            next_time    <= (now_t < start_time) ? start_time : next_adv;
          end
        end
        kas_pkg::S_DIV2:
          if (div_rsp.done)
            offset <= div_rsp.quotient[31] ? 32'h7FFF_FFFF : div_rsp.quotient[31:0];
        kas_pkg::S_WRAP:
          // past the end with no loop: hold the last frame
          if (offset >= {16'd0, frame_count} && loop_frames == 16'd0) begin
            offset    <= {16'd0, nm1};
            next_time <= now_t;
          end
        kas_pkg::S_DIV3:
          if (div_rsp.done)
            offset <= {16'd0, frame_count - loop_frames + div_rsp.remainder[15:0]};
        kas_pkg::S_APPLY: begin
          frame_now <= 16'({1'b0, first_frame}) + offset[15:0];
          model_now <= model_id;
          if (next_time < now_t) next_time <= now_t;
        end
        kas_pkg::S_FIX: begin
          if (33'(next_time) > lim200) next_time <= now_t;
          if (prev_time > now_t) prev_time <= now_t;
        end
        kas_pkg::S_BLEND:
          if (be_abs < 0) back_r <= 17'd65536;
          else back_r <= 17'd0;
        kas_pkg::S_DIV4:
          if (div_rsp.done) back_r <= 17'(19'd65536 - q_round);
        default: ;
      endcase
    end
  end

  // output register
  logic load_out;
  assign load_out = state == kas_pkg::S_OUT && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (result.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.prev_frame <= frame_before;
      result.cur_frame  <= frame_now;
      result.prev_model <= model_before;
      result.cur_model  <= model_now;
      result.back_blend <= back_r;
      result.anim_valid <= valid_r;
    end
  end

  assign result.valid = out_valid;

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, item.valid && item.ready, !item.ready)
  `ASSERT_IMPL(a_blend_range, clk, rst, result.valid, result.back_blend <= 17'd65536)
  `ASSERT_IMPL(a_invalid_zero, clk, rst, result.valid && !result.anim_valid, result.cur_frame == 16'd0 && result.back_blend == 17'd0)
  `ASSERT_IMPL(a_div_from_wait, clk, rst, div_rsp.done, state == kas_pkg::S_DIV1 || state == kas_pkg::S_DIV2 || state == kas_pkg::S_DIV3 || state == kas_pkg::S_DIV4)

endmodule

// ===== rtl/kas_div.sv =====
// Restoring divider, one quotient bit per cycle. Dividend is MSB aligned;
// short ops run 32 steps and leave the quotient in the low 32 bits.
module kas_div (
  input  logic              clk,
  input  logic              rst,
  input  kas_pkg::div_req_t req,
  output kas_pkg::div_rsp_t rsp
);

  logic [kas_pkg::DSR_W-1:0] rem;
  logic [kas_pkg::DVD_W-1:0] quo;
  logic [kas_pkg::DSR_W-1:0] dsr;
  logic [kas_pkg::CNT_W-1:0] cnt;
  logic                      busy;
  logic                      done;
  logic [kas_pkg::DSR_W:0]   trial;
  logic                      ge;

  assign trial = {rem, quo[kas_pkg::DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.long_op ? kas_pkg::DIV_LONG : kas_pkg::DIV_SHORT;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= ge ? kas_pkg::DSR_W'(trial - {1'b0, dsr}) : trial[kas_pkg::DSR_W-1:0];
      quo <= {quo[kas_pkg::DVD_W-2:0], ge};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== tb/sv/keyframe_animation_stepper_tb.sv =====
module keyframe_animation_stepper_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOGGLE = 512;
  localparam int ANIMS_MAX = 1024;
  localparam longint T_MAX = 64'sh7FFF_FFFF;
  localparam longint T_MIN = -T_MAX - 1;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE = 200;   // worst-case latency with margin

  // one render tick as driven onto the item channel
  typedef struct {
    logic signed [31:0] now_t;
    logic signed [31:0] end_t;
    logic [9:0]         num;
  } tick_t;

  // one blended frame pair as returned on the result channel
  typedef struct {
    logic [15:0] frame_prev;
    logic [15:0] frame_cur;
    logic [15:0] model_prev;
    logic [15:0] model_cur;
    logic [16:0] blend;
    logic        ok;
  } frame_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kas_cfg_if    cfg();
  kas_item_if   item();
  kas_result_if result();

  keyframe_animation_stepper dut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .item(item.sink), .result(result.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow descriptor and animation state
  // ---------------------------------------------------------------------------
  longint d_first, d_count, d_period, d_duration, d_loop, d_model, d_acount;

  logic [9:0]  bound_num;
  logic        bound_on;
  logic [15:0] fr_cur, fr_prev, md_cur, md_prev;
  longint      t_next, t_prev, t_start;

  tick_t       ticks_pending[$];
  frame_pair_t frames_due[$];
  int          errors = 0;
  bit          no_idle = 1'b0;

  function automatic longint clamp32(longint v);
    if (v > T_MAX) return T_MAX;
    if (v < T_MIN) return T_MIN;
    return v;
  endfunction

  // Advance the animation by one tick and return the frame pair it shows.
  function automatic frame_pair_t advance_frames(tick_t tk);
    longint now_v, end_v, n, per, rem, ofs, d, e, q, b;
    logic [9:0] idx;
    frame_pair_t r;
    now_v = tk.now_t;
    end_v = tk.end_t;
    n = d_count;
    per = d_period;
    idx = tk.num & ~10'(TOGGLE);
    r = '{default: '0};

    // bad descriptor or index: blank everything, drop the binding
    if (d_acount < 1 || d_acount > ANIMS_MAX || idx >= d_acount ||
        d_count == 0 || d_period == 0 || d_loop > d_count) begin
      bound_on = 1'b0;
      fr_cur = '0; fr_prev = '0; md_cur = '0; md_prev = '0;
      return r;
    end

    // (re)bind; late joiners skip ahead by the time already gone
    if (!bound_on || bound_num != tk.num) begin
      rem = end_v - now_v;
      bound_on = 1'b1;
      bound_num = tk.num;
      if (rem < 0) rem = 0;
      if (rem > d_duration) rem = d_duration;
      ofs = (d_duration - rem) / per;
      if (ofs >= n) ofs = n - 1;
      fr_cur = 16'(d_first + ofs);
      t_next = clamp32(now_v - 1);
      t_start = clamp32(now_v + rem - d_duration);
      md_cur = 16'(d_model);
    end

    if (end_v < now_v) begin
      // past the end: park on the last frame
      fr_cur = 16'(d_first + n - 1);
      fr_prev = fr_cur;
      md_cur = 16'(d_model);
      md_prev = md_cur;
    end else begin
      if (now_v >= t_next) begin
        fr_prev = fr_cur;
        t_prev = t_next;
        md_prev = md_cur;
        if (now_v < t_start) begin
          t_next = t_start;
          ofs = 0;
        end else begin
          t_next = clamp32(t_next + per);
          ofs = clamp32((t_next - t_start) / per);
        end
        if (ofs >= n) begin
          if (d_loop != 0) begin
            ofs = n - d_loop + (ofs - n) % d_loop;
          end else begin
            ofs = n - 1;
            t_next = now_v;
          end
        end
        if (ofs < 0) ofs = 0;
        fr_cur = 16'(d_first + ofs);
        md_cur = 16'(d_model);
        if (t_next < now_v) t_next = now_v;
      end
      if (t_next > now_v + 200) t_next = now_v;
      if (t_prev > now_v) t_prev = now_v;
      if (t_next != t_prev) begin
        d = t_next - t_prev;
        e = now_v - t_prev;
        if (d < 0) begin
          d = -d;
          e = -e;
        end
        if (e < 0) q = 0;
        else if (e > d) q = 65536;
        else q = (e * 131072 + d) / (2 * d);   // round half up
        b = 65536 - q;
        if (b < 0) b = 0;
        if (b > 65536) b = 65536;
        r.blend = 17'(b);
      end
    end

    r.frame_prev = fr_prev;
    r.frame_cur  = fr_cur;
    r.model_prev = md_prev;
    r.model_cur  = md_cur;
    r.ok = 1'b1;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Descriptor writes: shadow follows every completed transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      d_first = 0; d_count = 1; d_period = 50; d_duration = 50;
      d_loop = 0; d_model = 0; d_acount = 1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        kas_pkg::CFG_FIRST:    d_first    = cfg.data[14:0];
        kas_pkg::CFG_COUNT:    d_count    = cfg.data[15:0];
        kas_pkg::CFG_PERIOD:   d_period   = cfg.data[15:0];
        kas_pkg::CFG_DURATION: d_duration = cfg.data[30:0];
        kas_pkg::CFG_LOOP:     d_loop     = cfg.data[15:0];
        kas_pkg::CFG_MODEL:    d_model    = cfg.data[15:0];
        kas_pkg::CFG_ACOUNT:   d_acount   = cfg.data[10:0];
        default: ;    // unmapped index, dropped by the block too
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Item driver: predicts on each transfer, then offers the next tick
  // ---------------------------------------------------------------------------
  int    drv_gap;
  tick_t tick_on_bus;

  always @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
      drv_gap = 0;
      bound_num = '0; bound_on = 1'b0;
      fr_cur = '0; fr_prev = '0; md_cur = '0; md_prev = '0;
      t_next = 0; t_prev = 0; t_start = 0;
    end else begin
      if (item.valid && item.ready) frames_due.push_back(advance_frames(tick_on_bus));
      if (!item.valid || item.ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          item.valid <= 1'b0;
        end else if (ticks_pending.size() > 0) begin
          tick_on_bus = ticks_pending.pop_front();
          item.now_time    <= tick_on_bus.now_t;
          item.end_time    <= tick_on_bus.end_t;
          item.anim_number <= tick_on_bus.num;
          item.valid       <= 1'b1;
          drv_gap = no_idle ? 0 : pick_gap();
        end else begin
          item.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor with random back-pressure
  // ---------------------------------------------------------------------------
  int hold;

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    frame_pair_t w;
    if (rst) begin
      result.ready <= 1'b0;
      hold = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (frames_due.size() == 0) begin
          $error("result transfer with nothing outstanding");
          errors++;
        end else begin
          w = frames_due.pop_front();
          check_field("prev_frame", w.frame_prev, result.prev_frame);
          check_field("cur_frame",  w.frame_cur,  result.cur_frame);
          check_field("prev_model", w.model_prev, result.prev_model);
          check_field("cur_model",  w.model_cur,  result.cur_model);
          check_field("back_blend", w.blend,      result.back_blend);
          check_field("anim_valid", w.ok,         result.anim_valid);
        end
      end
      if (hold > 0) begin
        hold--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Called at a rising edge; leaves valid high for back-to-back transfers.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic set_descriptor(longint first, longint count, longint period,
                                longint dur, longint loops, longint model,
                                longint acount);
    @(posedge clk);
    write_reg(kas_pkg::CFG_FIRST,    32'(first));
    write_reg(kas_pkg::CFG_COUNT,    32'(count));
    write_reg(kas_pkg::CFG_PERIOD,   32'(period));
    write_reg(kas_pkg::CFG_DURATION, 32'(dur));
    write_reg(kas_pkg::CFG_LOOP,     32'(loops));
    write_reg(kas_pkg::CFG_MODEL,    32'(model));
    write_reg(kas_pkg::CFG_ACOUNT,   32'(acount));
    cfg.valid <= 1'b0;
  endtask

  // block must be idle before the descriptor changes
  task automatic drain();
    do @(negedge clk);
    while (ticks_pending.size() != 0 || frames_due.size() != 0 || item.valid);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_tick(longint now_v, longint end_v, int num);
    tick_t tk;
    tk.now_t = 32'(now_v);
    tk.end_t = 32'(end_v);
    tk.num   = 10'(num);
    ticks_pending.push_back(tk);
  endtask

  // Mostly well-formed playback of one animation with jittered tick spacing,
  // plus rebinds, past-end ticks and raw noise.
  task automatic random_ticks(int count);
    longint t, stop, step_max;
    int     num, r;
    t = longint'($urandom_range(0, 100000)) - 50000;
    num = $urandom_range(0, 3);
    stop = t + $urandom_range(0, 32'(d_duration > 100000 ? 100000 : d_duration + 1));
    step_max = (d_period > 0 && d_period < 100) ? 2 * d_period : 120;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        t += $urandom_range(0, 32'(step_max));
        if (t > T_MAX - 1000) t = 0;
        push_tick(t, stop, num);
      end else if (r < 82) begin
        // restart with a fresh number, often as a late join
        num = $urandom_range(0, 1) ? (num ^ TOGGLE) :
              ($urandom_range(0, 32'(d_acount > 3 ? d_acount + 1 : 4)) |
               ($urandom_range(0, 1) * TOGGLE));
        stop = t + $urandom_range(0, 32'(d_duration > 100000 ? 100000 : d_duration + 1))
               - $urandom_range(0, 50);
        push_tick(t, stop, num);
      end else if (r < 90) begin
        push_tick(t, t - $urandom_range(1, 1000), num);
      end else begin
        push_tick($signed($urandom), $signed($urandom), $urandom_range(0, 1023));
      end
    end
  endtask

  initial begin
    longint cnt, per;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    item.valid = 1'b0; item.now_time = '0; item.end_time = '0; item.anim_number = '0;
    result.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks on the reset descriptor (one frame, 50 ms, one animation)
    push_tick(0, 50, 0);
    push_tick(10, 50, 0);
    push_tick(25, 50, 0);
    push_tick(60, 50, 0);                  // past the end
    push_tick(100, 200, TOGGLE);           // toggle only: restart
    push_tick(120, 200, TOGGLE);
    push_tick(100, 50, TOGGLE);            // time runs backwards
    push_tick(T_MAX, T_MAX, 0);
    push_tick(T_MAX, T_MAX, TOGGLE);
    push_tick(T_MIN, T_MIN, 0);
    push_tick(T_MIN, T_MAX, TOGGLE);       // huge late-join window
    push_tick(T_MAX, T_MIN, 0);
    push_tick(0, 0, 1);                    // index beyond anim_count
    push_tick(0, 0, 1023);
    push_tick(5, 1000, 0);                 // rebind after invalid
    push_tick(400, 1000, 0);               // long gap, blend clamps
    push_tick(401, 1000, 0);
    push_tick(T_MIN + 3, T_MIN + 100, TOGGLE);
    drain();

    // unmapped register index must be dropped
    @(posedge clk);
    write_reg(3'd7, 32'hFFFF_FFFF);
    cfg.valid <= 1'b0;

    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0:  set_descriptor(0, 10, 50, 500, 3, 7, 4);
        1:  set_descriptor(32767, 32768, 65535, 64'h7FFF_FFFF, 32768, 65535, 1024);
        2:  set_descriptor(100, 5, 1, 0, 0, 1, 1);
        3:  set_descriptor(65, 40, 10, 400, 40, 3, 2);
        4:  set_descriptor(32767, 32768, 1, 64'h7FFF_FFFF, 1, 9, 3);  // frame wrap
        5:  set_descriptor(1, 4, 20, 80, 0, 2, 0);                     // no animations
        6:  set_descriptor(1, 4, 20, 80, 5, 2, 2);                     // loop > count
        7:  set_descriptor(1, 4, 20, 80, 0, 2, 1025);                  // too many
        8:  set_descriptor(1, 4, 0, 80, 0, 2, 2);                      // zero period
        9:  set_descriptor(1, 0, 20, 80, 0, 2, 2);                     // zero frames
        default: begin
          cnt = $urandom_range(1, 40);
          per = $urandom_range(1, 100);
          set_descriptor($urandom_range(0, 32767), cnt, per,
                         cnt * per + $urandom_range(0, 200) - 100 < 0 ? 0 :
                         cnt * per + $urandom_range(0, 200) - 100,
                         $urandom_range(0, 32'(cnt)), $urandom_range(0, 65535),
                         $urandom_range(1, 6));
        end
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      random_ticks((ph >= 5 && ph <= 9) ? 40 : 230);
      drain();
    end

    if (frames_due.size() != 0) begin
      $error("%0d results never arrived", frames_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
